// ----- src/gwm_pkg.sv -----
// Shared constants, types and helpers for the glob wildcard matcher.
// No dependencies; every other file of the block refers to this package.
package gwm_pkg;

  localparam int unsigned MAX_PATTERN_DEF = 32;
  localparam int unsigned PATTERN_STORE   = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned LEN_W           = 6;
  localparam int unsigned CHAR_W          = 8;

  localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;
  localparam logic [CHAR_W-1:0] LOWER_A   = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z   = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_GAP  = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0 = 3'd0,
    REG_PAT1 = 3'd1,
    REG_PAT2 = 3'd2,
    REG_PAT3 = 3'd3,
    REG_LEN  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic at_start;
    logic out_full;
  } back_stat_t;

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] r;
    r = c;
    if (c >= LOWER_A && c <= LOWER_Z) begin
      r = c - CASE_GAP;
    end
    return r;
  endfunction

endpackage

// ----- src/gwm_if.sv -----
// Valid/ready channel interfaces for subject items and match verdicts.
// Depends on gwm_pkg for the character width.
interface gwm_in_if;
  logic                        valid;
  logic                        ready;
  logic [gwm_pkg::CHAR_W-1:0]  subject_char;
  logic                        last_char;
  modport source (output valid, subject_char, last_char, input ready);
  modport sink   (input valid, subject_char, last_char, output ready);
endinterface

interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic last;
  modport source (output valid, matched, last, input ready);
  modport sink   (input valid, matched, last, output ready);
endinterface

// ----- src/gwm_front.sv -----
// Front end: accepts subject items and classifies them against every pattern byte.
// Depends on gwm_pkg and gwm_in_if; feeds the item queue.
module gwm_front #(
  parameter int unsigned MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
  gwm_in_if.sink                          in_i,
  input  logic [8*MAX_PATTERN-1:0]        pat_i,
  output logic                            push_valid_o,
  input  logic                            push_ready_i,
  output logic [MAX_PATTERN:0]            push_data_o
);

  logic [gwm_pkg::CHAR_W-1:0] subj_fold;
  logic [MAX_PATTERN-1:0]     char_hit;

  assign subj_fold = gwm_pkg::fold_case(in_i.subject_char);

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      char_hit[i] = (pat_i[8*i +: 8] == gwm_pkg::ANY_CHAR) ||
                    (gwm_pkg::fold_case(pat_i[8*i +: 8]) == subj_fold);
    end
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;
  assign push_data_o  = {in_i.last_char, char_hit};

endmodule

// ----- src/gwm_fifo.sv -----
// Short item queue between the classifying front end and the automaton.
// Depends on gwm_pkg for the default depth (a power of two, at least 2).
module gwm_fifo #(
  parameter int unsigned DW    = gwm_pkg::MAX_PATTERN_DEF + 1,
  parameter int unsigned DEPTH = gwm_pkg::QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/gwm_back.sv -----
// Back end: live-position automaton with star closure and the verdict register.
// Depends on gwm_pkg and gwm_out_if; drains the item queue.
module gwm_back #(
  parameter int unsigned MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  output logic                   pop_ready_o,
  input  logic [MAX_PATTERN:0]   pop_data_i,
  input  logic [MAX_PATTERN-1:0] en_i,
  input  logic [MAX_PATTERN-1:0] star_i,
  input  logic [MAX_PATTERN:0]   end_i,
  gwm_out_if.source              out_o,
  output gwm_pkg::back_stat_t    stat_o
);

  localparam int unsigned W      = MAX_PATTERN + 1;
  localparam int unsigned LEVELS = $clog2(W);
  localparam logic [W-1:0] START = W'(1);

  // Parallel-prefix closure: a live bit runs forward across consecutive stars.
  function automatic logic [W-1:0] close_run(input logic [W-1:0] v,
                                             input logic [W-2:0] s);
    logic [W-1:0] g, p, g_n, p_n;
    g = v;
    p = {s, 1'b0};
    for (int k = 0; k < LEVELS; k++) begin
      g_n = g;
      p_n = p;
      for (int j = 0; j < W; j++) begin
        if (j >= (1 << k)) begin
          g_n[j] = g[j] | (p[j] & g[j - (1 << k)]);
          p_n[j] = p[j] & p[j - (1 << k)];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

  logic [W-1:0]           live_q, live_d;
  logic [W-1:0]           cl, nxt_pre, nxt;
  logic [MAX_PATTERN-1:0] adv, stay, char_hit;
  logic                   item_last, hit, pop;
  logic                   out_valid_q, out_valid_d;
  logic                   matched_q, last_q;

  assign char_hit  = pop_data_i[MAX_PATTERN-1:0];
  assign item_last = pop_data_i[MAX_PATTERN];

  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign pop         = pop_valid_i & pop_ready_o;

  always_comb begin
    cl = close_run(live_q, star_i);
    for (int i = 0; i < MAX_PATTERN; i++) begin
      adv[i]  = cl[i] & en_i[i] & ~star_i[i] & char_hit[i];
      stay[i] = cl[i] & star_i[i];
    end
    nxt_pre = {adv, 1'b0} | {1'b0, stay};
    nxt     = close_run(nxt_pre, star_i);
    hit     = |(nxt & end_i);
    live_d  = live_q;
    if (pop) begin
      live_d = item_last ? START : nxt;
    end
    out_valid_d = pop | (out_valid_q & ~out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= START;
      out_valid_q <= 1'b0;
    end else begin
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      matched_q <= hit;
      last_q    <= item_last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.matched   = matched_q;
  assign out_o.last      = last_q;
  assign stat_o.at_start = (live_q == START);
  assign stat_o.out_full = out_valid_q;

endmodule

// ----- src/glob_wildcard_matcher_core.sv -----
// Top level of the glob wildcard matcher: pattern registers, decode, front, queue, back.
// Depends on gwm_pkg, gwm_if, gwm_front, gwm_fifo and gwm_back.
//
// channel   dir  handshake    payload
// in_i      in   valid/ready  subject_char[7:0], last_char
// out_o     out  valid/ready  matched, last
// cfg       in   cfg_we_i     cfg_idx_i[2:0], cfg_wdata_i[63:0]
//
// One item per cycle sustained while out_o is ready; an accepted item goes to out_o through
// the queue stage, then the verdict register after the automaton update.
// The automaton update is one parallel-prefix star closure, a step, another closure.
// Reset clears the pattern and restarts the live vector at the start position.
// The two-entry queue holds up to two items while out_o stalls; in_i.ready
// drops once it is full.
module glob_wildcard_matcher_core #(
  parameter int unsigned MAX_PATTERN = gwm_pkg::MAX_PATTERN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  gwm_in_if.sink                            in_i,
  gwm_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [gwm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gwm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned W       = MAX_PATTERN + 1;
  localparam int unsigned STORE_W = 8 * gwm_pkg::PATTERN_STORE;

  logic [STORE_W-1:0]            pat_q;
  logic [gwm_pkg::LEN_W-1:0]     plen_q;
  logic [8*MAX_PATTERN-1:0]      pat_bytes;
  logic [MAX_PATTERN-1:0]        nz;
  logic [MAX_PATTERN-1:0]        en_d, en_q, star_d, star_q;
  logic [W-1:0]                  end_d, end_q;
  logic                          q_push_valid, q_push_ready;
  logic [W-1:0]                  q_push_data, q_pop_data;
  logic                          q_pop_valid, q_pop_ready;
  gwm_pkg::back_stat_t           back_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= '0;
    end else if (cfg_we_i) begin
      case (gwm_pkg::cfg_reg_e'(cfg_idx_i))
        gwm_pkg::REG_PAT0: pat_q[0*gwm_pkg::CFG_DATA_W +: gwm_pkg::CFG_DATA_W] <= cfg_wdata_i;
        gwm_pkg::REG_PAT1: pat_q[1*gwm_pkg::CFG_DATA_W +: gwm_pkg::CFG_DATA_W] <= cfg_wdata_i;
        gwm_pkg::REG_PAT2: pat_q[2*gwm_pkg::CFG_DATA_W +: gwm_pkg::CFG_DATA_W] <= cfg_wdata_i;
        gwm_pkg::REG_PAT3: pat_q[3*gwm_pkg::CFG_DATA_W +: gwm_pkg::CFG_DATA_W] <= cfg_wdata_i;
        gwm_pkg::REG_LEN:  plen_q <= cfg_wdata_i[gwm_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_byte
    if (g < gwm_pkg::PATTERN_STORE) begin : g_stored
      assign pat_bytes[8*g +: 8] = pat_q[8*g +: 8];
    end else begin : g_absent
      assign pat_bytes[8*g +: 8] = '0;
    end
  end

  // Position i is in use when it is below the length and no byte at or before it is zero.
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      nz[i] = (pat_bytes[8*i +: 8] != '0);
    end
    for (int i = 0; i < MAX_PATTERN; i++) begin
      en_d[i]   = (i < int'(plen_q)) &&
                  (&(nz | ~MAX_PATTERN'((W'(1) << (i + 1)) - W'(1))));
      star_d[i] = en_d[i] && (pat_bytes[8*i +: 8] == gwm_pkg::STAR_CHAR);
    end
    end_d[0] = 1'b0;
    for (int i = 1; i < W; i++) begin
      end_d[i] = en_d[i-1] && ((i == MAX_PATTERN) || !en_d[i % MAX_PATTERN]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q   <= '0;
      star_q <= '0;
      end_q  <= '0;
    end else begin
      en_q   <= en_d;
      star_q <= star_d;
      end_q  <= end_d;
    end
  end

  gwm_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .in_i         (in_i),
    .pat_i        (pat_bytes),
    .push_valid_o (q_push_valid),
    .push_ready_i (q_push_ready),
    .push_data_o  (q_push_data)
  );

  gwm_fifo #(
    .DW    (W),
    .DEPTH (gwm_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (q_push_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  (q_push_data),
    .pop_valid_o  (q_pop_valid),
    .pop_ready_i  (q_pop_ready),
    .pop_data_o   (q_pop_data)
  );

  gwm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (q_pop_valid),
    .pop_ready_o (q_pop_ready),
    .pop_data_i  (q_pop_data),
    .en_i        (en_q),
    .star_i      (star_q),
    .end_i       (end_q),
    .out_o       (out_o),
    .stat_o      (back_stat)
  );

`ifndef SYNTHESIS
  a_accept_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> q_pop_valid)
    else $error("accepted item not visible in queue");

  a_pop_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_valid && q_pop_ready |=> back_stat.out_full)
    else $error("drained item produced no verdict");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_valid && q_pop_ready && q_pop_data[MAX_PATTERN] |=> back_stat.at_start)
    else $error("live vector not restarted after final item");
`endif

endmodule

// ----- tb/sv/gwm_match_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the glob wildcard matcher: tracks pattern register writes, predicts
// the verdict of each accepted subject item and compares it with the verdict channel.
// Depends on gwm_pkg and the channel interfaces in gwm_if.
module gwm_match_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  gwm_in_if                              subj_i,
  gwm_out_if                             verdict_i,
  input  logic                           cfg_we_i,
  input  logic [gwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gwm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    open_count_o
);

  localparam int unsigned SLOTS = gwm_pkg::MAX_PATTERN_DEF;
  localparam logic [SLOTS:0] START_ONLY = (SLOTS + 1)'(1);

  typedef struct packed {
    logic matched;
    logic last;
  } verdict_t;

  logic [gwm_pkg::CFG_DATA_W-1:0] pat_word [4];
  logic [gwm_pkg::LEN_W-1:0]      pat_len;
  logic [SLOTS:0]                 live;
  verdict_t                       verdict_q [$];
  verdict_t                       want;
  verdict_t                       got;
  int unsigned                    fails;

  function automatic logic [gwm_pkg::CHAR_W-1:0] pat_byte(int unsigned i);
    return pat_word[(i / 8) % 4][(i % 8) * 8 +: 8];
  endfunction

  function automatic logic [gwm_pkg::CHAR_W-1:0] upcase(logic [gwm_pkg::CHAR_W-1:0] c);
    if (c >= gwm_pkg::LOWER_A && c <= gwm_pkg::LOWER_Z) begin
      return c - gwm_pkg::CASE_GAP;
    end
    return c;
  endfunction

  // length in use: register value clipped to the store, cut at the first zero byte
  function automatic int unsigned used_len();
    int unsigned n;
    n = 32'(pat_len);
    if (n > gwm_pkg::PATTERN_STORE) n = gwm_pkg::PATTERN_STORE;
    if (n > SLOTS) n = SLOTS;
    for (int unsigned i = 0; i < n; i++) begin
      if (pat_byte(i) == 8'h00) return i;
    end
    return n;
  endfunction

  function automatic logic [SLOTS:0] close_stars(logic [SLOTS:0] v, int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (v[i] && pat_byte(i) == gwm_pkg::STAR_CHAR) v[i+1] = 1'b1;
    end
    return v;
  endfunction

  function automatic verdict_t consume_char(logic [gwm_pkg::CHAR_W-1:0] c, logic last_in);
    int unsigned                 n;
    logic [SLOTS:0]              cur;
    logic [SLOTS:0]              nxt;
    logic [gwm_pkg::CHAR_W-1:0]  p;
    verdict_t                    v;
    n   = used_len();
    cur = close_stars(live, n);
    nxt = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (cur[i]) begin
        p = pat_byte(i);
        if (p == gwm_pkg::STAR_CHAR) begin
          nxt[i] = 1'b1;
        end else if (p == gwm_pkg::ANY_CHAR || upcase(p) == upcase(c)) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
    nxt       = close_stars(nxt, n);
    v.matched = (n > 0) && nxt[n];
    v.last    = last_in;
    live      = last_in ? START_ONLY : nxt;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (pat_word[i]) pat_word[i] = '0;
      pat_len = '0;
      live    = START_ONLY;
      verdict_q.delete();
      fails   = 0;
    end else begin
      if (verdict_i.valid && verdict_i.ready) begin
        got.matched = verdict_i.matched;
        got.last    = verdict_i.last;
        if (verdict_q.size() == 0) begin
          $error("verdict with no item pending: matched=%0b last=%0b",
                 got.matched, got.last);
          fails++;
        end else begin
          want = verdict_q.pop_front();
          if (got.matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, got.matched);
            fails++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            fails++;
          end
        end
      end
      if (subj_i.valid && subj_i.ready) begin
        verdict_q.push_back(consume_char(subj_i.subject_char, subj_i.last_char));
      end
      if (cfg_we_i) begin
        case (gwm_pkg::cfg_reg_e'(cfg_idx_i))
          gwm_pkg::REG_PAT0: pat_word[0] = cfg_wdata_i;
          gwm_pkg::REG_PAT1: pat_word[1] = cfg_wdata_i;
          gwm_pkg::REG_PAT2: pat_word[2] = cfg_wdata_i;
          gwm_pkg::REG_PAT3: pat_word[3] = cfg_wdata_i;
          gwm_pkg::REG_LEN:  pat_len = cfg_wdata_i[gwm_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    open_count_o <= verdict_q.size();
  end

endmodule

// ----- tb/sv/tb_glob_wildcard_matcher_core.sv -----
`timescale 1ns / 100ps
// Top of the glob wildcard matcher bench: clock, reset, pattern writes, subject items,
// verdict back-pressure and the final verdict. Depends on gwm_pkg, gwm_if,
// glob_wildcard_matcher_core and gwm_match_checker.
module tb_glob_wildcard_matcher_core;

  localparam int unsigned ITEM_TARGET  = 1900;
  localparam int unsigned IDLE_STOP    = 1600;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [gwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [gwm_pkg::CFG_DATA_W-1:0] cfg_wdata_i;
  int unsigned                    fail_count;
  int unsigned                    open_count;

  logic [gwm_pkg::CHAR_W-1:0]     pat_text [gwm_pkg::PATTERN_STORE];
  logic [gwm_pkg::LEN_W-1:0]      pat_len_now;
  int unsigned                    chars_sent;
  int unsigned                    quiet_cycles;
  int unsigned                    stall_left;
  bit                             idle_on;

  gwm_in_if  subj_ch ();
  gwm_out_if verdict_ch ();

  glob_wildcard_matcher_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (subj_ch),
    .out_o       (verdict_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  gwm_match_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .subj_i       (subj_ch),
    .verdict_i    (verdict_ch),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // verdict back-pressure in random bursts, started only while idle_on is set
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      verdict_ch.ready <= 1'b0;
      stall_left       <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      verdict_ch.ready <= 1'b0;
      stall_left       <= $urandom_range(0, 16);
    end else begin
      verdict_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (subj_ch.valid && subj_ch.ready) ||
        (verdict_ch.valid && verdict_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic logic [gwm_pkg::CHAR_W-1:0] letter_byte();
    logic [gwm_pkg::CHAR_W-1:0] b;
    b = 8'h41 + gwm_pkg::CHAR_W'($urandom_range(0, 2));
    if ($urandom_range(0, 1) != 0) b = b | gwm_pkg::CASE_GAP;
    return b;
  endfunction

  function automatic logic [gwm_pkg::CHAR_W-1:0] pattern_byte();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 5) return gwm_pkg::STAR_CHAR;
    if (r < 9) return gwm_pkg::ANY_CHAR;
    if (r < 17) return letter_byte();
    return gwm_pkg::CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic logic [gwm_pkg::CHAR_W-1:0] subject_byte();
    int unsigned r;
    r = $urandom_range(0, 63);
    if (r == 0) return 8'h00;
    if (r < 28) return letter_byte();
    if (r < 31) return (r == 29) ? gwm_pkg::STAR_CHAR : gwm_pkg::ANY_CHAR;
    return gwm_pkg::CHAR_W'($urandom_range(1, 255));
  endfunction

  function automatic bit is_letter(logic [gwm_pkg::CHAR_W-1:0] b);
    return (b | gwm_pkg::CASE_GAP) >= gwm_pkg::LOWER_A &&
           (b | gwm_pkg::CASE_GAP) <= gwm_pkg::LOWER_Z;
  endfunction

  task automatic send_char(logic [gwm_pkg::CHAR_W-1:0] c, logic last_in);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      subj_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    subj_ch.valid        <= 1'b1;
    subj_ch.subject_char <= c;
    subj_ch.last_char    <= last_in;
    do @(posedge clk_i); while (!subj_ch.ready);
    chars_sent++;
  endtask

  task automatic send_text(string s, bit terminate);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], terminate && i == s.len() - 1);
    end
  endtask

  // all verdicts in before the registers change
  task automatic settle();
    subj_ch.valid <= 1'b0;
    do @(posedge clk_i); while (open_count != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(gwm_pkg::cfg_reg_e r, logic [gwm_pkg::CFG_DATA_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= d;
    @(posedge clk_i);
  endtask

  task automatic load_pattern(logic [gwm_pkg::LEN_W-1:0] n);
    logic [gwm_pkg::CFG_DATA_W-1:0] w [4];
    foreach (pat_text[i]) w[i / 8][(i % 8) * 8 +: 8] = pat_text[i];
    settle();
    write_reg(gwm_pkg::REG_PAT0, w[0]);
    write_reg(gwm_pkg::REG_PAT1, w[1]);
    write_reg(gwm_pkg::REG_PAT2, w[2]);
    write_reg(gwm_pkg::REG_PAT3, w[3]);
    write_reg(gwm_pkg::REG_LEN, gwm_pkg::CFG_DATA_W'(n));
    cfg_we_i    <= 1'b0;
    pat_len_now = n;
  endtask

  task automatic set_text(string s);
    foreach (pat_text[i]) pat_text[i] = (i < s.len()) ? s[i] : 8'h00;
  endtask

  task automatic roll_pattern();
    int unsigned               sel;
    logic [gwm_pkg::LEN_W-1:0] n;
    sel = $urandom_range(0, 19);
    if (sel == 0) n = '0;
    else if (sel == 1) n = gwm_pkg::LEN_W'($urandom_range(33, 63));
    else if (sel < 5) n = gwm_pkg::LEN_W'($urandom_range(9, 32));
    else n = gwm_pkg::LEN_W'($urandom_range(1, 8));
    foreach (pat_text[i]) pat_text[i] = pattern_byte();
    if ($urandom_range(0, 9) == 0) begin
      pat_text[$urandom_range(0, gwm_pkg::PATTERN_STORE - 1)] = 8'h00;
    end
    load_pattern(n);
  endtask

  // well-formed subjects follow the pattern, with an occasional corrupted byte
  task automatic send_subject(bit well_formed, bit terminate);
    logic [gwm_pkg::CHAR_W-1:0] s [$];
    logic [gwm_pkg::CHAR_W-1:0] b;
    int unsigned                n;
    if (well_formed) begin
      n = (32'(pat_len_now) > gwm_pkg::PATTERN_STORE) ? gwm_pkg::PATTERN_STORE :
                                                          32'(pat_len_now);
      for (int unsigned i = 0; i < n; i++) begin
        b = pat_text[i];
        if (b == 8'h00) break;
        if (b == gwm_pkg::STAR_CHAR) begin
          repeat ($urandom_range(0, 3)) s.push_back(subject_byte());
        end else if (b == gwm_pkg::ANY_CHAR) begin
          s.push_back(subject_byte());
        end else if (is_letter(b) && $urandom_range(0, 1) != 0) begin
          s.push_back(b ^ gwm_pkg::CASE_GAP);
        end else begin
          s.push_back(b);
        end
      end
      if (s.size() > 0 && $urandom_range(0, 3) == 0) begin
        s[$urandom_range(0, s.size() - 1)] = subject_byte();
      end
    end else begin
      repeat ($urandom_range(1, 12)) s.push_back(subject_byte());
    end
    if (s.size() == 0) s.push_back(subject_byte());
    foreach (s[i]) send_char(s[i], terminate && i == s.size() - 1);
  endtask

  initial begin
    int unsigned n_subj;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= '0;
    cfg_wdata_i          <= '0;
    subj_ch.valid        <= 1'b0;
    subj_ch.subject_char <= '0;
    subj_ch.last_char    <= 1'b0;
    idle_on              = 1'b1;
    chars_sent           = 0;
    pat_len_now          = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pattern registers at reset value: empty pattern
    send_text("a", 1'b1);

    // case folding, any-byte with a high byte, star
    set_text("A?*Z");
    load_pattern(6'd4);
    send_char("a", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char("x", 1'b0);
    send_char("z", 1'b1);

    // oversized length, terminator inside it, zero subject byte, high bytes unfolded
    set_text("");
    pat_text[0] = gwm_pkg::STAR_CHAR;
    pat_text[1] = 8'hE9;
    load_pattern(6'd63);
    send_char(8'h00, 1'b0);
    send_char(8'hC9, 1'b0);
    send_char(8'hE9, 1'b1);

    // zero byte cuts the pattern short; subject left open across the next write
    set_text("ab");
    pat_text[3] = "c";
    pat_text[4] = "d";
    load_pattern(6'd5);
    send_text("AB", 1'b1);
    send_char("A", 1'b0);
    set_text("x?");
    load_pattern(6'd2);
    send_char(8'h01, 1'b1);

    // full-length pattern
    foreach (pat_text[i]) pat_text[i] = gwm_pkg::STAR_CHAR;
    pat_text[gwm_pkg::PATTERN_STORE - 1] = "q";
    load_pattern(6'd32);
    send_char("Q", 1'b1);

    set_text("?");
    load_pattern(6'd1);
    send_char(8'h00, 1'b1);

    foreach (pat_text[i]) pat_text[i] = 8'hFF;
    load_pattern(6'd32);
    send_char(8'hFF, 1'b1);

    set_text("");
    load_pattern(6'd0);
    send_char(8'h7F, 1'b1);

    while (chars_sent < ITEM_TARGET) begin
      idle_on = chars_sent < IDLE_STOP;
      roll_pattern();
      n_subj = $urandom_range(4, 14);
      for (int unsigned i = 0; i < n_subj; i++) begin
        send_subject($urandom_range(0, 9) < 7, i < n_subj - 1 || $urandom_range(0, 5) != 0);
      end
    end

    subj_ch.valid <= 1'b0;
    do @(posedge clk_i); while (open_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && open_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
